FILE: design/rfd_pkg.sv
// Shared types and constants for the rangefinder frame detector.
`default_nettype none

package rfd_pkg;

  localparam int unsigned DATA_FRAME_LEN_DEF = 9;

  localparam logic [7:0] HEAD_DATA = 8'h59;
  localparam logic [7:0] HEAD_RESP = 8'h5A;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 1;

  typedef enum logic [1:0] {
    DISC_NONE  = 2'd0,
    DISC_STRAY = 2'd1,
    DISC_CLEAR = 2'd2
  } discard_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_RESP = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] running_sum;
    logic [7:0] id_byte;
    logic [7:0] status_byte;
  } state_t;

  typedef struct packed {
    logic       frame_found;
    kind_t      frame_kind;
    logic       sum_ok;
    logic [7:0] response_id;
    logic [7:0] response_status;
    discard_t   discard;
  } result_t;

endpackage

`default_nettype wire

FILE: design/rfd_in_stage.sv
// Input register: holds one received byte until the output side can take its result.
`default_nettype none

module rfd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       take,
  output logic            q_valid,
  output logic [7:0]      q_byte,
  output logic            advance
);

  assign advance  = q_valid && take;
  assign s_tready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_tready) begin
      q_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      q_byte <= s_tdata;
    end
  end

endmodule

`default_nettype wire

FILE: design/rfd_step.sv
// Per-byte frame logic: next buffer state and the result for one byte.
`default_nettype none

module rfd_step #(
  parameter int unsigned DATA_FRAME_LEN = rfd_pkg::DATA_FRAME_LEN_DEF
) (
  input  wire rfd_pkg::state_t st,
  input  wire logic [7:0]      rx_byte,
  output rfd_pkg::state_t      st_next,
  output rfd_pkg::result_t     res
);

  localparam logic [7:0] DLEN = 8'(DATA_FRAME_LEN);

  logic [7:0]      n;
  rfd_pkg::state_t upd;
  logic            clr;

  always_comb begin
    n   = st.byte_count + 8'd1;
    upd = st;
    case (n)
      8'd1:    upd.first_byte  = rx_byte;
      8'd2:    upd.second_byte = rx_byte;
      8'd3:    upd.id_byte     = rx_byte;
      8'd4:    upd.status_byte = rx_byte;
      default: upd.byte_count  = n;
    endcase
    upd.byte_count  = n;
    upd.running_sum = st.running_sum + rx_byte;

    clr                 = 1'b0;
    res.frame_found     = 1'b0;
    res.frame_kind      = rfd_pkg::KIND_DATA;
    res.sum_ok          = 1'b0;
    res.response_id     = 8'd0;
    res.response_status = 8'd0;
    res.discard         = rfd_pkg::DISC_NONE;

    if (upd.first_byte == rfd_pkg::HEAD_DATA) begin
      if (n == DLEN && upd.second_byte == rfd_pkg::HEAD_DATA && st.running_sum == rx_byte) begin
        res.frame_found = 1'b1;
        res.sum_ok      = 1'b1;
        clr             = 1'b1;
      end else if (n > DLEN) begin
        res.discard = rfd_pkg::DISC_CLEAR;
        clr         = 1'b1;
      end
    end else if (upd.first_byte == rfd_pkg::HEAD_RESP) begin
      if (n >= 8'd2) begin
        if (n == upd.second_byte) begin
          res.frame_found     = 1'b1;
          res.frame_kind      = rfd_pkg::KIND_RESP;
          res.sum_ok          = (st.running_sum == rx_byte);
          res.response_id     = (n >= 8'd4) ? upd.id_byte : 8'd0;
          res.response_status = (n >= 8'd5) ? upd.status_byte : 8'd0;
          clr                 = 1'b1;
        end else if (n > upd.second_byte) begin
          res.discard = rfd_pkg::DISC_CLEAR;
          clr         = 1'b1;
        end
      end
    end else begin
      res.discard = rfd_pkg::DISC_STRAY;
      clr         = 1'b1;
    end

    st_next = clr ? '0 : upd;
  end

endmodule

`default_nettype wire

FILE: design/rfd_out_stage.sv
// Output register: packs and holds one result beat until the sink takes it.
`default_nettype none

module rfd_out_stage (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  load,
  input  wire rfd_pkg::result_t                      res,
  output logic                                       can_load,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [rfd_pkg::OUT_TDATA_W-1:0]            m_tdata,
  output logic [rfd_pkg::OUT_TUSER_W-1:0]            m_tuser
);

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      m_tdata <= {4'd0, res.discard, res.response_status, res.response_id,
                  res.sum_ok, res.frame_found};
      m_tuser <= res.frame_kind;
    end
  end

endmodule

`default_nettype wire

FILE: design/rangefinder_frame_detector.sv
// Top level of the rangefinder frame detector.
//
//  channel | dir | signals                      | content
//  --------+-----+------------------------------+-------------------------------
//  s       | in  | s_tvalid s_tready s_tdata[7:0]  | rx_byte
//  m       | out | m_tvalid m_tready m_tdata[23:0] | found, sum_ok, id, status,
//          |     | m_tuser[0]                   | discard; tuser = frame_kind
//
// One byte per cycle while m is not stalled; each result passes through the input register
// and then the output register. The buffer state updates as a byte moves
// from the input register to the output register.
// Synchronous reset clears both valid flags and the buffer state.
// A stall on m holds the output beat and backs up into the input register.
`default_nettype none

module rangefinder_frame_detector #(
  parameter int unsigned DATA_FRAME_LEN = rfd_pkg::DATA_FRAME_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [rfd_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] rx_byte
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [0] frame_found, [1] sum_ok, [9:2] response_id, [17:10] response_status,
  // [19:18] discard, [23:20] zero
  output logic [rfd_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic [rfd_pkg::OUT_TUSER_W-1:0]        m_tuser   // [0] frame_kind
);

  logic             take;
  logic             q_valid;
  logic [7:0]       q_byte;
  logic             advance;
  rfd_pkg::state_t  st;
  rfd_pkg::state_t  st_next;
  rfd_pkg::result_t res;

  rfd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .q_valid  (q_valid),
    .q_byte   (q_byte),
    .advance  (advance)
  );

  rfd_step #(
    .DATA_FRAME_LEN (DATA_FRAME_LEN)
  ) u_step (
    .st      (st),
    .rx_byte (q_byte),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  rfd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (q_valid),
    .res      (res),
    .can_load (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

FILE: design/rfd_checker.sv
// Port-level checks for the rangefinder frame detector, bound to the top level.
`default_nettype none

module rfd_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [rfd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input wire logic [rfd_pkg::OUT_TUSER_W-1:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_found_no_discard: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[19:18] == rfd_pkg::DISC_NONE)
    else $error("frame reported together with a discard");

  a_no_frame_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> !m_tuser[0] && !m_tdata[1] && m_tdata[17:2] == 16'd0)
    else $error("frame fields set without a frame");

  a_data_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] && !m_tuser[0] |-> m_tdata[1] && m_tdata[17:2] == 16'd0)
    else $error("bad data frame fields");

  a_discard_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[19:18] == rfd_pkg::DISC_NONE ||
                  m_tdata[19:18] == rfd_pkg::DISC_STRAY ||
                  m_tdata[19:18] == rfd_pkg::DISC_CLEAR) && m_tdata[23:20] == 4'd0)
    else $error("invalid discard code or padding");

endmodule

bind rangefinder_frame_detector rfd_checker u_rfd_checker (.*);

`default_nettype wire
